@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, sampled on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/jcmr_pkg.sv @@
// ----------------------------------------------------------------------------
// jcmr_pkg
// shared constants, types and helpers of the jpeg comment marker rewriter
// ----------------------------------------------------------------------------
package jcmr_pkg;

    localparam int COMMENT_DEPTH = 32;
    localparam int CNT_W  = $clog2(COMMENT_DEPTH + 1);
    localparam int ADDR_W = (COMMENT_DEPTH > 1) ? $clog2(COMMENT_DEPTH) : 1;
    localparam int POS_W  = $clog2(COMMENT_DEPTH + 7);

    // marker codes
    localparam logic [7:0] MK_FF  = 8'hFF;
    localparam logic [7:0] MK_SOI = 8'hD8;
    localparam logic [7:0] MK_EOI = 8'hD9;
    localparam logic [7:0] MK_SOS = 8'hDA;
    localparam logic [7:0] MK_COM = 8'hFE;
    localparam logic [7:0] MK_SOF_LO = 8'hC0;
    localparam logic [7:0] MK_SOF_HI = 8'hCF;
    localparam logic [7:0] MK_DHT = 8'hC4;
    localparam logic [7:0] MK_JPG = 8'hC8;
    localparam logic [7:0] MK_DAC = 8'hCC;

    // status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_GARBAGE     = 3'd1;
    localparam logic [2:0] ST_NOT_JPEG    = 3'd2;
    localparam logic [2:0] ST_PREMATURE   = 3'd3;
    localparam logic [2:0] ST_BAD_LENGTH  = 3'd4;
    localparam logic [2:0] ST_MARK_ORDER  = 3'd5;

    // one command per stream word, expanded by the back end
    typedef struct packed {
        logic [7:0]       byte_a;
        logic [7:0]       byte_b;
        logic [1:0]       nbytes;
        logic             insert;
        logic [CNT_W-1:0] cnt;
        logic             last;
        logic [2:0]       status;
    } cmd_t;

    // comment store write request
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } ld_t;

    // queue status
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic is_sof(input logic [7:0] m);
        logic r;
        r = (m >= MK_SOF_LO) && (m <= MK_SOF_HI) &&
            (m != MK_DHT) && (m != MK_JPG) && (m != MK_DAC);
        return r;
    endfunction

endpackage

@@ sv/jpeg_comment_marker_rewriter_unit.sv @@
// path: a stream word passes through the command queue, the sequencer's command register and the output register
// throughput: one output word per cycle while out_ready is high and commands are queued; a stream word
//   gives one output word per byte, at least one; the comment insertion gives comment_count + 6 words
// comment loads are taken only once the back end has drained
// reset: rst_n async active low clears parser state, queue and output valid
// ----------------------------------------------------------------------------
// jpeg_comment_marker_rewriter_unit
// filters a jpeg byte stream: strips or keeps comment segments and inserts a
// new comment segment from the preloaded bytes, if any, before the first frame or end-of-image marker
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jpeg_comment_marker_rewriter_unit
(
    input  logic       clk,
    input  logic       rst_n,
    // keep_comments register
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    // input words
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       operation,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    // output words
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       run_end,
    output logic       file_done,
    output logic [2:0] status
);
    import jcmr_pkg::*;

    // front end to queue
    logic    push;
    cmd_t    push_cmd;
    // queue to back end
    cmd_t    head;
    q_stat_t q_stat;
    logic    pop;
    // comment store writes go straight to the back end, which owns the memory
    ld_t     ld;
    logic    back_busy;

    // parser: classifies each stream word into a short command
    jcmr_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .q_stat      (q_stat),
        .back_busy   (back_busy),
        .push        (push),
        .push_cmd    (push_cmd),
        .ld          (ld)
    );

    // decouples the parser from output back-pressure
    jcmr_cmd_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    // sequencer: one output word per cycle while out_ready is high, plays out the comment burst
    jcmr_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ld         (ld),
        .head       (head),
        .q_empty    (q_stat.empty),
        .pop        (pop),
        .busy       (back_busy),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .run_end    (run_end),
        .file_done  (file_done),
        .status     (status)
    );

    // comment writes only happen while nothing is queued or playing out
    `ASSERT_IMPL(a_load_idle, ld.en, q_stat.empty && !back_busy, "comment write while busy")
    // the queue is never pushed when full nor popped when empty
    `ASSERT_IMPL(a_queue_ok, (push && q_stat.full) || (pop && q_stat.empty), 1'b0, "queue misuse")
    // status-only words carry a zero byte
    `ASSERT_IMPL(a_zero_byte, out_valid && !byte_valid, out_byte == 8'h00, "status word not zero")
    // a popped command keeps the back end busy in the next cycle
    `ASSERT_NEXT(a_pop_busy, pop, back_busy, "popped command lost")

endmodule

@@ sv/jcmr_front.sv @@
// ----------------------------------------------------------------------------
// jcmr_front
// accepts words, parses the header markers and issues one command per stream word
// ----------------------------------------------------------------------------
module jcmr_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic            cfg_wr_data,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            operation,
    input  logic [7:0]      data_byte,
    input  logic            last_byte,
    input  jcmr_pkg::q_stat_t q_stat,
    input  logic            back_busy,
    output logic            push,
    output jcmr_pkg::cmd_t  push_cmd,
    output jcmr_pkg::ld_t   ld
);
    import jcmr_pkg::*;

    typedef enum logic [8:0] {
        PH_START0 = 9'b000000001,
        PH_START1 = 9'b000000010,
        PH_HALTED = 9'b000000100,
        PH_SEEK   = 9'b000001000,
        PH_MARKER = 9'b000010000,
        PH_LEN_HI = 9'b000100000,
        PH_LEN_LO = 9'b001000000,
        PH_BODY   = 9'b010000000,
        PH_PASS   = 9'b100000000
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic             keep_reg;
    logic             garbage_reg, garbage_next;
    logic [15:0]      left_reg, left_next;
    logic [7:0]       len_hi_reg, len_hi_next;
    logic             copy_reg, copy_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [2:0]       err_reg, err_next;
    logic             accept;
    logic             load_acc;
    logic             strm_acc;
    logic [15:0]      seg_len;
    cmd_t             cmd;

    // loads wait until the back end has drained, so a burst never sees a rewrite
    assign in_ready = operation ? (q_stat.empty && !back_busy) : !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign load_acc = accept && operation;
    assign strm_acc = accept && !operation;
    assign seg_len  = {len_hi_reg, data_byte};

    always_comb
    begin
        phase_next  = phase_reg;
        garbage_next = garbage_reg;
        left_next   = left_reg;
        len_hi_next = len_hi_reg;
        copy_next   = copy_reg;
        count_next  = count_reg;
        err_next    = err_reg;
        cmd.byte_a  = 8'h00;
        cmd.byte_b  = 8'h00;
        cmd.nbytes  = 2'd0;
        cmd.insert  = 1'b0;
        cmd.cnt     = count_reg;
        cmd.last    = last_byte;

        unique case (phase_reg)
            PH_START0:
            begin
                if (data_byte == MK_FF)
                begin
                    phase_next = PH_START1;
                end
                else
                begin
                    err_next   = ST_NOT_JPEG;
                    phase_next = PH_HALTED;
                end
            end
            PH_START1:
            begin
                if (data_byte == MK_SOI)
                begin
                    cmd.byte_a = MK_FF;
                    cmd.byte_b = MK_SOI;
                    cmd.nbytes = 2'd2;
                    phase_next = PH_SEEK;
                end
                else
                begin
                    err_next   = ST_NOT_JPEG;
                    phase_next = PH_HALTED;
                end
            end
            PH_HALTED:
            begin
                phase_next = PH_HALTED;
            end
            PH_SEEK:
            begin
                if (data_byte == MK_FF)
                    phase_next = PH_MARKER;
                else
                    garbage_next = 1'b1;
            end
            PH_MARKER:
            begin
                if (data_byte != MK_FF)
                begin
                    if (garbage_reg)
                    begin
                        err_next     = ST_GARBAGE;
                        garbage_next = 1'b0;
                    end
                    priority if (is_sof(data_byte) || data_byte == MK_EOI)
                    begin
                        cmd.insert = (count_reg != '0);
                        cmd.byte_a = MK_FF;
                        cmd.byte_b = data_byte;
                        cmd.nbytes = 2'd2;
                        phase_next = PH_PASS;
                    end
                    else if (data_byte == MK_SOS)
                    begin
                        err_next   = ST_MARK_ORDER;
                        phase_next = PH_SEEK;
                    end
                    else
                    begin
                        copy_next = (data_byte != MK_COM) || keep_reg;
                        if (copy_next)
                        begin
                            cmd.byte_a = MK_FF;
                            cmd.byte_b = data_byte;
                            cmd.nbytes = 2'd2;
                        end
                        phase_next = PH_LEN_HI;
                    end
                end
            end
            PH_LEN_HI:
            begin
                len_hi_next = data_byte;
                if (copy_reg)
                begin
                    cmd.byte_a = data_byte;
                    cmd.nbytes = 2'd1;
                end
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                if (copy_reg)
                begin
                    cmd.byte_a = data_byte;
                    cmd.nbytes = 2'd1;
                end
                if (seg_len < 16'd2)
                begin
                    // too short: treated as a bare length field
                    err_next   = ST_BAD_LENGTH;
                    left_next  = 16'd0;
                    phase_next = PH_SEEK;
                end
                else
                begin
                    left_next  = seg_len - 16'd2;
                    phase_next = (seg_len == 16'd2) ? PH_SEEK : PH_BODY;
                end
            end
            PH_BODY:
            begin
                if (copy_reg)
                begin
                    cmd.byte_a = data_byte;
                    cmd.nbytes = 2'd1;
                end
                left_next = left_reg - 16'd1;
                if (left_reg == 16'd1)
                    phase_next = PH_SEEK;
            end
            PH_PASS:
            begin
                cmd.byte_a = data_byte;
                cmd.nbytes = 2'd1;
            end
            default:
            begin
                phase_next = PH_START0;
            end
        endcase

        // end of file before pass-through
        if (last_byte)
        begin
            if (phase_next == PH_START0 || phase_next == PH_START1)
                err_next = ST_NOT_JPEG;
            else if (phase_next != PH_HALTED && phase_next != PH_PASS)
                err_next = ST_PREMATURE;
        end
        cmd.status = err_next;
    end

    assign push     = strm_acc;
    assign push_cmd = cmd;

    assign ld.en   = load_acc && (count_reg < CNT_W'(COMMENT_DEPTH));
    assign ld.addr = count_reg[ADDR_W-1:0];
    assign ld.data = data_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg    <= 1'b0;
            phase_reg   <= PH_START0;
            garbage_reg <= 1'b0;
            left_reg    <= 16'd0;
            len_hi_reg  <= 8'd0;
            copy_reg    <= 1'b0;
            count_reg   <= '0;
            err_reg     <= ST_OK;
        end
        else
        begin
            if (cfg_wr_en)
                keep_reg <= cfg_wr_data;
            if (ld.en)
                count_reg <= count_reg + CNT_W'(1);
            if (strm_acc)
            begin
                if (last_byte)
                begin
                    // per-file state back to reset, keep flag stays
                    phase_reg   <= PH_START0;
                    garbage_reg <= 1'b0;
                    left_reg    <= 16'd0;
                    len_hi_reg  <= 8'd0;
                    copy_reg    <= 1'b0;
                    count_reg   <= '0;
                    err_reg     <= ST_OK;
                end
                else
                begin
                    phase_reg   <= phase_next;
                    garbage_reg <= garbage_next;
                    left_reg    <= left_next;
                    len_hi_reg  <= len_hi_next;
                    copy_reg    <= copy_next;
                    count_reg   <= count_next;
                    err_reg     <= err_next;
                end
            end
        end
    end

endmodule

@@ sv/jcmr_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// jcmr_cmd_fifo
// two-entry command queue between front and back end
// ----------------------------------------------------------------------------
module jcmr_cmd_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  jcmr_pkg::cmd_t    push_cmd,
    input  logic              pop,
    output jcmr_pkg::cmd_t    head,
    output jcmr_pkg::q_stat_t q_stat
);
    import jcmr_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    assign head         = slot_reg[rd_ptr_reg];
    assign q_stat.full  = (fill_reg == 2'd2);
    assign q_stat.empty = (fill_reg == 2'd0);

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                fill_reg <= fill_reg + 2'd1;
            else if (pop && !push)
                fill_reg <= fill_reg - 2'd1;
        end
    end

endmodule

@@ sv/jcmr_back.sv @@
// ----------------------------------------------------------------------------
// jcmr_back
// expands commands into output words, owns the comment store
// ----------------------------------------------------------------------------
module jcmr_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  jcmr_pkg::ld_t  ld,
    input  jcmr_pkg::cmd_t head,
    input  logic           q_empty,
    output logic           pop,
    output logic           busy,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_byte,
    output logic           byte_valid,
    output logic           run_end,
    output logic           file_done,
    output logic [2:0]     status
);
    import jcmr_pkg::*;

    logic [7:0]       mem [COMMENT_DEPTH];
    logic [7:0]       rd_data_reg;
    cmd_t             cur_reg;
    logic             act_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] total;
    logic [POS_W-1:0] rd_idx;
    logic [15:0]      com_len;
    logic             fire;
    logic             at_last;
    logic [7:0]       word;
    logic             word_valid;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             byte_valid_reg;
    logic             run_end_reg;
    logic             file_done_reg;
    logic [2:0]       status_reg;

    assign com_len = 16'(cur_reg.cnt) + 16'd2;

    always_comb
    begin
        if (cur_reg.insert)
            total = POS_W'(cur_reg.cnt) + POS_W'(6);
        else if (cur_reg.nbytes == 2'd0)
            total = POS_W'(1);
        else
            total = POS_W'(cur_reg.nbytes);
    end

    assign at_last = (pos_reg == total - POS_W'(1));
    assign fire    = act_reg && (!out_valid_reg || out_ready);
    assign pop     = (!act_reg || (fire && at_last)) && !q_empty;
    assign busy    = act_reg;

    always_comb
    begin
        word_valid = cur_reg.insert || (cur_reg.nbytes != 2'd0);
        priority if (!word_valid)
            word = 8'h00;
        else if (!cur_reg.insert)
            word = (pos_reg == '0) ? cur_reg.byte_a : cur_reg.byte_b;
        else if (pos_reg == POS_W'(0))
            word = MK_FF;
        else if (pos_reg == POS_W'(1))
            word = MK_COM;
        else if (pos_reg == POS_W'(2))
            word = com_len[15:8];
        else if (pos_reg == POS_W'(3))
            word = com_len[7:0];
        else if (pos_reg < POS_W'(cur_reg.cnt) + POS_W'(4))
            word = rd_data_reg;
        else if (pos_reg == POS_W'(cur_reg.cnt) + POS_W'(4))
            word = cur_reg.byte_a;
        else
            word = cur_reg.byte_b;
    end

    always_comb
    begin
        if (pop)
            pos_next = '0;
        else if (fire)
            pos_next = pos_reg + POS_W'(1);
        else
            pos_next = pos_reg;
    end

    // read one position ahead so the data lines up with pos_reg
    assign rd_idx = pos_next - POS_W'(4);

    always_ff @(posedge clk)
    begin
        if (ld.en)
            mem[ld.addr] <= ld.data;
        if (rd_idx < POS_W'(COMMENT_DEPTH))
            rd_data_reg <= mem[rd_idx[ADDR_W-1:0]];
        if (pop)
            cur_reg <= head;
        if (fire)
        begin
            out_byte_reg   <= word;
            byte_valid_reg <= word_valid;
            run_end_reg    <= at_last;
            file_done_reg  <= cur_reg.last;
            status_reg     <= cur_reg.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg       <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (pop)
                act_reg <= 1'b1;
            else if (fire && at_last)
                act_reg <= 1'b0;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign run_end    = run_end_reg;
    assign file_done  = file_done_reg;
    assign status     = status_reg;

endmodule
